// ===== sv/bchc_pkg.sv =====
`default_nettype none

package bchc_pkg;

	localparam int unsigned MAX_BLOCK_BYTES = 4096;
	localparam int unsigned CNT_W = $clog2(MAX_BLOCK_BYTES + 2);
	localparam int unsigned POS_W = 16;
	localparam int unsigned PIDX_W = 5;
	localparam int unsigned OFS_W = 15;

	localparam logic [31:0] CRC_SEED = ~32'h0;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [POS_W-1:0] POS_RESET = POS_W'(3);
	localparam logic [PIDX_W-1:0] PIDX_RESET = PIDX_W'(2);

	localparam logic [1:0] ST_CRC_OK = 2'd0;
	localparam logic [1:0] ST_LOCATED = 2'd1;
	localparam logic [1:0] ST_NO_FIX = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	// Hamming walk state: parity, code position of the next data bit and
	// exponent of the next power of two to skip.
	typedef struct packed {
		logic [POS_W-1:0] parity;
		logic [POS_W-1:0] ncp;
		logic [PIDX_W-1:0] npi;
	} pos_state_t;

	// Block summary, captured on the last beat.
	typedef struct packed {
		logic [31:0] crc;
		logic [POS_W-1:0] ecc;
		logic [POS_W-1:0] ncp;
		logic too_long;
		logic [31:0] stored_crc;
		logic [POS_W-1:0] stored_ecc;
	} blk_sum_t;

	typedef struct packed {
		logic match;
		logic [1:0] status;
		logic [OFS_W-1:0] offset;
	} verdict_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic low;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			low = c[0] ^ b[k];
			c = c >> 1;
			if (low) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic pos_state_t pos_byte(input pos_state_t st, input logic [7:0] b);
		pos_state_t r;
		logic [POS_W-1:0] nxt;
		r = st;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				r.parity = r.parity ^ r.ncp;
			end
			nxt = r.ncp + POS_W'(1);
			// skip the parity slot at the next power of two
			if (r.npi < PIDX_W'(POS_W) && nxt == (POS_W'(1) << r.npi)) begin
				nxt = nxt + POS_W'(1);
				r.npi = r.npi + PIDX_W'(1);
			end
			r.ncp = nxt;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/bchc_judge.sv =====
`default_nettype none

module bchc_judge (
	input wire bchc_pkg::blk_sum_t sum,
	output bchc_pkg::verdict_t verdict
);
	import bchc_pkg::*;

	logic [POS_W-1:0] syn;
	logic [POS_W-1:0] msb;
	logic single;
	logic past;
	logic [POS_W-1:0] ofs;

	assign syn = sum.ecc ^ sum.stored_ecc;
	assign single = (syn & (syn - POS_W'(1))) == '0;
	assign past = syn >= sum.ncp;

	// highest set bit of the syndrome
	always_comb begin
		msb = '0;
		for (int i = 1; i < POS_W; i++) begin
			if (syn[i]) begin
				msb = POS_W'(i);
			end
		end
	end

	assign ofs = syn - POS_W'(2) - msb;

	always_comb begin
		verdict.match = (sum.crc == sum.stored_crc);
		verdict.offset = '0;
		if (sum.too_long) begin
			verdict.status = ST_TOO_LONG;
		end else if (verdict.match) begin
			verdict.status = ST_CRC_OK;
		end else if (single || past) begin
			verdict.status = ST_NO_FIX;
		end else begin
			verdict.status = ST_LOCATED;
			verdict.offset = ofs[OFS_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== sv/block_crc32_hamming_check_top.sv =====
`default_nettype none

// Block CRC32 and Hamming syndrome checker.
// Throughput: one byte beat per cycle unless in_stall holds the input; the CRC and Hamming walk
// for all eight bits of a byte run in the single accumulator stage.
// Output: after the last beat is taken, the block passes through the block summary
// register, then the result register, which drives the verdict outputs.
// Reset: accumulators go to seed (CRC all ones, parity 0, position 3), pipeline empties.
module block_crc32_hamming_check_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic last,
	input wire logic [31:0] stored_crc,
	input wire logic [15:0] stored_ecc,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] crc_value,
	output logic [15:0] ecc_value,
	output logic crc_match,
	output logic [1:0] status,
	output logic [14:0] fix_bit_offset
);
	import bchc_pkg::*;

	// Running accumulators for the block in flight.
	logic [31:0] crc_q;
	pos_state_t pos_q;
	logic [CNT_W-1:0] count_q;

	// Block summary stage and result register.
	blk_sum_t sum_s1;
	logic valid_s1;
	logic out_valid_q;
	logic [31:0] crc_value_q;
	logic [POS_W-1:0] ecc_value_q;
	verdict_t verdict_q;

	logic in_acc;
	logic out_load;
	logic absorb;
	logic [31:0] crc_nx;
	pos_state_t pos_nx;
	pos_state_t pos_reset;
	logic [CNT_W-1:0] count_nx;
	verdict_t verdict;

	// Result register frees up when empty or when its beat leaves.
	assign out_load = !out_valid_q || !out_stall;
	// Hold input only while a finished summary cannot move on.
	assign in_stall = valid_s1 && !out_load;
	assign in_acc = in_valid && !in_stall;

	// Bytes past the limit are not absorbed; the count saturates at limit+1.
	assign absorb = count_q < CNT_W'(MAX_BLOCK_BYTES);
	assign crc_nx = absorb ? crc_byte(crc_q, data_byte) : crc_q;
	assign pos_nx = absorb ? pos_byte(pos_q, data_byte) : pos_q;
	assign count_nx = absorb ? count_q + CNT_W'(1) : CNT_W'(MAX_BLOCK_BYTES + 1);

	assign pos_reset = '{parity: '0, ncp: POS_RESET, npi: PIDX_RESET};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_SEED;
			pos_q <= '{parity: '0, ncp: POS_RESET, npi: PIDX_RESET};
			count_q <= '0;
		end else if (in_acc) begin
			if (last) begin
				// reload for the next block
				crc_q <= CRC_SEED;
				pos_q <= pos_reset;
				count_q <= '0;
			end else begin
				crc_q <= crc_nx;
				pos_q <= pos_nx;
				count_q <= count_nx;
			end
		end
	end

	// Capture the block summary on the last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && last) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last) begin
			sum_s1.crc <= crc_nx;
			sum_s1.ecc <= pos_nx.parity;
			sum_s1.ncp <= pos_nx.ncp;
			sum_s1.too_long <= !absorb;
			sum_s1.stored_crc <= stored_crc;
			sum_s1.stored_ecc <= stored_ecc;
		end
	end

	bchc_judge u_judge (
		.sum(sum_s1),
		.verdict(verdict)
	);

	// Result register: advance when free, drop the beat once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			crc_value_q <= sum_s1.crc;
			ecc_value_q <= sum_s1.ecc;
			verdict_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;
	assign ecc_value = ecc_value_q;
	assign crc_match = verdict_q.match;
	assign status = verdict_q.status;
	assign fix_bit_offset = verdict_q.offset;

endmodule

`default_nettype wire
